@@ hw/rtl/rcv_pkg.sv @@
package rcv_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FWIDTH_W   = 12;
    localparam int FHEIGHT_W  = 16;

    // per channel arithmetic widths
    localparam int SUM_W      = 12;  // sum of nine bytes
    localparam int CROSS_W    = 10;  // sum of four bytes
    localparam int PRE_W      = 13;  // signed result before clamping
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int BLUR_SHIFT = 16;

    // floor(x / 9) == (x * 7282) >> 16 for every x below 32768
    localparam logic [RECIP_W-1:0] BLUR_RECIP = 13'd7282;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    typedef enum logic [1:0] {
        KM_SHARPEN = 2'd0,
        KM_BLUR    = 2'd1,
        KM_EDGE    = 2'd2
    } t_kernel_mode;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_last;
    } t_out_beat;

endpackage

@@ hw/rtl/rcv_ram.sv @@
module rcv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rcv_filter.sv @@
module rcv_filter
    import rcv_pkg::*;
(
    input  logic               i_clk,
    input  logic [1:0]         i_kernel_mode,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [CROSS_W-1:0] i_cross,
    input  logic [PIX_W-1:0]   i_center,
    output logic [PIX_W-1:0]   o_pix
);

    logic [PRE_W-1:0]  c5;
    logic [PRE_W-1:0]  c9;
    logic [PROD_W-1:0] prod;
    logic [PRE_W-1:0]  n_pre;
    logic [PRE_W-1:0]  r_pre;

    always_comb begin
        c5   = PRE_W'({i_center, 2'b00}) + PRE_W'(i_center);
        c9   = PRE_W'({i_center, 3'b000}) + PRE_W'(i_center);
        prod = PROD_W'(i_sum) * PROD_W'(BLUR_RECIP);
        case (t_kernel_mode'(i_kernel_mode))
            KM_BLUR: begin
                n_pre = PRE_W'(prod[PROD_W-1:BLUR_SHIFT]);
            end
            KM_EDGE: begin
                n_pre = c9 - PRE_W'(i_sum);
            end
            default: begin
                n_pre = c5 - PRE_W'(i_cross);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    // two's complement clamp to 0..255
    always_comb begin
        if (r_pre[PRE_W-1]) begin
            o_pix = '0;
        end else if (r_pre[PRE_W-2:PIX_W] != '0) begin
            o_pix = '1;
        end else begin
            o_pix = r_pre[PIX_W-1:0];
        end
    end

endmodule

@@ hw/rtl/rgb_convolution_3x3.sv @@
// 3x3 convolution on an rgb pixel stream in raster order, one pixel per beat.
// each channel is filtered on its own with the kernel picked by kernel_mode
// (sharpen, box blur, edge detect) and clamped to 0..255. a result beat
// leaves only for interior pixels; it is produced while pixel (row+1, col+1)
// comes in. the block takes one pixel per clock, sustained, as long as the
// output side keeps taking beats: the line stores are two MAX_WIDTH x 24
// rams that are read when a pixel is accepted and written back in the
// cycle after, so each pixel costs one read and one write per ram. a result
// is registered through stages 1, 2 and 3 into the output queue. an eight
// beat output queue decouples the two sides; input ready drops only when the
// queue plus the beats still in the pipe would fill it. the line stores are
// not cleared after reset, so the block accepts pixels right away. config
// writes are always taken and should be done while the block is idle.
module rgb_convolution_3x3
    import rcv_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;
    localparam int CW = (WW > FWIDTH_W) ? WW : FWIDTH_W;
    localparam int QDEPTH = 8;
    localparam int QAW = $clog2(QDEPTH);
    localparam int OCC_W = QAW + 2;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [1:0]           r_kernel_mode;
    logic [FWIDTH_W-1:0]  r_frame_width;
    logic [FHEIGHT_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode  <= KM_SHARPEN;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_data[1:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FHEIGHT_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // last column and last row of the effective frame
    logic [CW-1:0]        fw_ext;
    logic [AW-1:0]        w_last;
    logic [FHEIGHT_W-1:0] h_last;

    always_comb begin
        fw_ext = CW'(r_frame_width);
        if (fw_ext == '0) begin
            w_last = '0;
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(fw_ext - CW'(1));
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else begin
            h_last = r_frame_height - FHEIGHT_W'(1);
        end
    end

    // ---------------------------------------------------------------------
    // stage 0: accept, position counters, line store read
    // ---------------------------------------------------------------------
    logic                 accept;
    logic [AW-1:0]        col_cur;
    logic [FHEIGHT_W-1:0] row_cur;
    logic [AW-1:0]        r_col;
    logic [FHEIGHT_W-1:0] r_row;
    logic [AW-1:0]        n_col;
    logic [FHEIGHT_W-1:0] n_row;
    logic                 emit0;
    logic                 last0;
    logic                 fwd0;

    // stage 1 registers
    logic                 r_s1_act;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    logic                 r_s1_fwd;
    logic [AW-1:0]        r_s1_col;
    logic [RGB_W-1:0]     r_s1_px;
    logic [RGB_W-1:0]     r_fwd_up;
    logic [RGB_W-1:0]     r_fwd_mid;

    assign accept = i_in_valid & o_in_ready;

    always_comb begin
        col_cur = i_in_data.frame_start ? '0 : r_col;
        row_cur = i_in_data.frame_start ? '0 : r_row;
        emit0 = (row_cur >= FHEIGHT_W'(2)) && (col_cur >= AW'(2))
              && (col_cur <= w_last) && (row_cur <= h_last);
        last0 = (row_cur == h_last) && (col_cur == w_last);
        // previous pixel writes this column back in the same cycle
        fwd0  = r_s1_act && (r_s1_col == col_cur);
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_cur >= w_last) begin
                n_col = '0;
                n_row = (row_cur >= h_last) ? '0 : row_cur + FHEIGHT_W'(1);
            end else begin
                n_col = col_cur + AW'(1);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_act  <= 1'b0;
            r_s1_emit <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_act  <= accept;
            r_s1_emit <= accept & emit0;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: line store data back, window update, write back, sums
    // ---------------------------------------------------------------------
    logic [RGB_W-1:0] ram_up_q;
    logic [RGB_W-1:0] ram_mid_q;
    logic [RGB_W-1:0] up_res;
    logic [RGB_W-1:0] mid_res;
    logic [RGB_W-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        r_s1_last <= last0;
        r_s1_fwd  <= fwd0;
        r_s1_col  <= col_cur;
        r_s1_px   <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        // values the current stage 1 pixel is writing, for a same-column reader
        r_fwd_up  <= mid_res;
        r_fwd_mid <= r_s1_px;
    end

    assign up_res  = r_s1_fwd ? r_fwd_up  : ram_up_q;
    assign mid_res = r_s1_fwd ? r_fwd_mid : ram_mid_q;

    // upper row takes what the middle row held, middle row takes the new pixel
    rcv_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_act),
        .i_waddr (r_s1_col),
        .i_wdata (mid_res),
        .i_raddr (col_cur),
        .o_rdata (ram_up_q)
    );

    rcv_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_act),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_raddr (col_cur),
        .o_rdata (ram_mid_q)
    );

    // window: entries 0..2 are column col-2 (top to bottom), 3..5 column col-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_act) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up_res;
            r_win[4] <= mid_res;
            r_win[5] <= r_s1_px;
        end
    end

    // stage 2 registers
    logic               r_s2_emit;
    logic               r_s2_last;
    logic [SUM_W-1:0]   r_s2_sum   [3];
    logic [CROSS_W-1:0] r_s2_cross [3];
    logic [PIX_W-1:0]   r_s2_ctr   [3];
    logic [PIX_W-1:0]   pix        [3];

    // stage 3 control
    logic r_s3_emit;
    logic r_s3_last;

    // channel 0 is blue, 1 green, 2 red
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [PIX_W-1:0]   v_ul, v_uc, v_ur, v_ml, v_mc, v_mr, v_ll, v_lc, v_lr;
        logic [CROSS_W-1:0] cross_sum;
        logic [SUM_W-1:0]   sum;

        always_comb begin
            v_ul  = r_win[0][ch*PIX_W +: PIX_W];
            v_uc  = r_win[3][ch*PIX_W +: PIX_W];
            v_ur  = up_res[ch*PIX_W +: PIX_W];
            v_ml  = r_win[1][ch*PIX_W +: PIX_W];
            v_mc  = r_win[4][ch*PIX_W +: PIX_W];
            v_mr  = mid_res[ch*PIX_W +: PIX_W];
            v_ll  = r_win[2][ch*PIX_W +: PIX_W];
            v_lc  = r_win[5][ch*PIX_W +: PIX_W];
            v_lr  = r_s1_px[ch*PIX_W +: PIX_W];
            cross_sum = CROSS_W'(v_uc) + CROSS_W'(v_ml) + CROSS_W'(v_mr)
                      + CROSS_W'(v_lc);
            sum   = SUM_W'(cross_sum) + SUM_W'(v_mc)
                  + SUM_W'(v_ul) + SUM_W'(v_ur) + SUM_W'(v_ll) + SUM_W'(v_lr);
        end

        always_ff @(posedge i_clk) begin
            r_s2_sum[ch]   <= sum;
            r_s2_cross[ch] <= cross_sum;
            r_s2_ctr[ch]   <= v_mc;
        end

        // stage 2 kernel arithmetic, registered into stage 3, clamp after
        rcv_filter u_filter (
            .i_clk         (i_clk),
            .i_kernel_mode (r_kernel_mode),
            .i_sum         (r_s2_sum[ch]),
            .i_cross       (r_s2_cross[ch]),
            .i_center      (r_s2_ctr[ch]),
            .o_pix         (pix[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
            r_s3_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_s1_emit;
            r_s3_emit <= r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_s3_last <= r_s2_last;
    end

    // ---------------------------------------------------------------------
    // output queue
    // ---------------------------------------------------------------------
    t_out_beat        r_queue [QDEPTH];
    t_out_beat        push_beat;
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_cnt;
    logic             push;
    logic             pop;
    logic [OCC_W-1:0] occupancy;

    assign push = r_s3_emit;
    assign pop  = o_out_valid & i_out_ready;

    always_comb begin
        push_beat.red_out    = pix[2];
        push_beat.green_out  = pix[1];
        push_beat.blue_out   = pix[0];
        push_beat.frame_last = r_s3_last;
    end

    // reserve a slot for every result still in the pipe
    assign occupancy  = OCC_W'(r_cnt) + OCC_W'(r_s1_emit) + OCC_W'(r_s2_emit)
                      + OCC_W'(r_s3_emit);
    assign o_in_ready = occupancy < OCC_W'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= push_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_queue[r_rd_ptr];

endmodule
